// ===== hw/rtl/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg: shared types for the priority call dispatcher
// Command codes, field widths and the queue entry layout.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned CLASS_W = 2;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  // one queued request: id in the upper half, service length in the lower
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] ticks;
  } entry_t;

  typedef struct packed {
    cmd_e               command;
    logic [CLASS_W-1:0] request_class;
    logic [ID_W-1:0]    request_id;
    logic [TICKS_W-1:0] service_ticks;
  } item_t;

endpackage

// ===== hw/rtl/pcd_req_if.sv =====
// ----------------------------------------------------------------------------
// pcd_req_if: request channel of the priority call dispatcher
// Carries arrivals and tick commands with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcd_req_if;
  import pcd_pkg::*;

  logic               valid;
  logic               ready;
  cmd_e               command;
  logic [CLASS_W-1:0] request_class;
  logic [ID_W-1:0]    request_id;
  logic [TICKS_W-1:0] service_ticks;

  modport source (
    output valid, command, request_class, request_id, service_ticks,
    input  ready
  );

  modport sink (
    input  valid, command, request_class, request_id, service_ticks,
    output ready
  );

endinterface

// ===== hw/rtl/pcd_res_if.sv =====
// ----------------------------------------------------------------------------
// pcd_res_if: result channel of the priority call dispatcher
// One word per accepted request word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcd_res_if;
  import pcd_pkg::*;

  logic               valid;
  logic               ready;
  logic               answered;
  logic [ID_W-1:0]    answered_id;
  logic [CLASS_W-1:0] answered_class;
  logic               all_idle;
  logic               arrival_dropped;

  modport source (
    output valid, answered, answered_id, answered_class, all_idle, arrival_dropped,
    input  ready
  );

  modport sink (
    input  valid, answered, answered_id, answered_class, all_idle, arrival_dropped,
    output ready
  );

endinterface

// ===== hw/rtl/priority_call_dispatcher.sv =====
// ----------------------------------------------------------------------------
// priority_call_dispatcher: strict-priority, non-preemptive call server
// Per-class FIFOs in one RAM and a head register per class.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes one word per cycle while ready is high: an arrival (command
//   CMD_ARRIVE) queues request_id/service_ticks in its class FIFO, or is
//   dropped if its class is out of range or that FIFO is full, and a tick
//   (CMD_TICK) runs one time step. Every request word gives exactly one word
//   on res_o. A word is held in the input register; the dispatch decision and
//   all queue pointer updates happen as it moves to the result register. One
//   word per cycle passes while res_o is not stalled, set by the single pass
//   through the class pick and the FIFO pointers; the queue RAM has one write
//   and one read port and a head register per class, refilled through the RAM
//   read register after a dispatch. Reset empties every FIFO and frees the
//   server at once; the RAM itself is not cleared and needs no clearing pass.
//   If res_o is stalled the result is held, one more word is taken into the
//   input register, and ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module priority_call_dispatcher #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NUM_CLASSES = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  pcd_req_if.sink   req_i,
  pcd_res_if.source res_o
);
  import pcd_pkg::*;

  localparam int unsigned SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CSEL_W    = $clog2(NUM_CLASSES);
  localparam int unsigned ADDR_W    = CSEL_W + SLOT_W;
  localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // input register
  logic  s1_valid_q;
  item_t s1_item_q;
  logic  advance;

  // queue state
  logic [SLOT_W-1:0]  head_q  [NUM_CLASSES];
  logic [SLOT_W-1:0]  head_d  [NUM_CLASSES];
  logic [SLOT_W-1:0]  tail_q  [NUM_CLASSES];
  logic [SLOT_W-1:0]  tail_d  [NUM_CLASSES];
  logic [CNT_W-1:0]   count_q [NUM_CLASSES];
  logic [CNT_W-1:0]   count_d [NUM_CLASSES];
  logic [TICKS_W-1:0] busy_q, busy_d;

  // head-of-queue registers
  entry_t                 front_q   [NUM_CLASSES];
  entry_t                 front_eff [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] front_load;

  // queue RAM
  entry_t              store_q [MEM_DEPTH];
  entry_t              rdata_q;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  entry_t              mem_wdata;
  logic                refill_q, refill_d;
  logic [CSEL_W-1:0]   refill_cls_q, refill_cls_d;

  // result register
  logic               res_valid_q;
  logic               answered_q, answered_d;
  logic [ID_W-1:0]    ans_id_q, ans_id_d;
  logic [CLASS_W-1:0] ans_cls_q, ans_cls_d;
  logic               idle_q, idle_d;
  logic               dropped_q, dropped_d;

  // dispatch helpers
  logic              class_ok;
  logic [CSEL_W-1:0] arr_cls;
  logic              found;
  logic [CSEL_W-1:0] pick;
  entry_t            pick_entry;

  assign advance     = s1_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || advance;

  assign res_o.valid           = res_valid_q;
  assign res_o.answered        = answered_q;
  assign res_o.answered_id     = ans_id_q;
  assign res_o.answered_class  = ans_cls_q;
  assign res_o.all_idle        = idle_q;
  assign res_o.arrival_dropped = dropped_q;

  assign arr_cls  = CSEL_W'(s1_item_q.request_class);
  assign class_ok = 32'(s1_item_q.request_class) < NUM_CLASSES;

  // a head refilled from the RAM last cycle is taken straight from read data
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      front_eff[c] = (refill_q && refill_cls_q == CSEL_W'(c)) ? rdata_q : front_q[c];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_d[c]  = head_q[c];
      tail_d[c]  = tail_q[c];
      count_d[c] = count_q[c];
    end
    busy_d       = busy_q;
    mem_we       = 1'b0;
    mem_waddr    = {arr_cls, tail_q[arr_cls]};
    mem_wdata    = '{id: s1_item_q.request_id, ticks: s1_item_q.service_ticks};
    mem_re       = 1'b0;
    mem_raddr    = '0;
    refill_d     = 1'b0;
    refill_cls_d = refill_cls_q;
    front_load   = '0;
    answered_d   = 1'b0;
    ans_id_d     = '0;
    ans_cls_d    = '0;
    idle_d       = 1'b0;
    dropped_d    = 1'b0;
    found        = 1'b0;
    pick         = '0;

    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!found && count_q[c] != '0) begin
        found = 1'b1;
        pick  = CSEL_W'(c);
      end
    end
    pick_entry = front_eff[pick];

    if (advance) begin
      if (s1_item_q.command == CMD_ARRIVE) begin
        if (!class_ok || count_q[arr_cls] == FULL_CNT) begin
          dropped_d = 1'b1;
        end else begin
          mem_we           = 1'b1;
          tail_d[arr_cls]  = next_slot(tail_q[arr_cls]);
          count_d[arr_cls] = count_q[arr_cls] + 1'b1;
          if (count_q[arr_cls] == '0) begin
            front_load[arr_cls] = 1'b1;
          end
        end
      end else if (busy_q != '0) begin
        busy_d = busy_q - 1'b1;
      end else if (found) begin
        answered_d    = 1'b1;
        ans_id_d      = pick_entry.id;
        ans_cls_d     = CLASS_W'(pick);
        head_d[pick]  = next_slot(head_q[pick]);
        count_d[pick] = count_q[pick] - 1'b1;
        busy_d        = (pick_entry.ticks != '0) ? pick_entry.ticks - 1'b1 : '0;
        // next in line lives in the RAM; fetch it into the head register
        if (count_q[pick] > ONE_CNT) begin
          mem_re       = 1'b1;
          mem_raddr    = {pick, next_slot(head_q[pick])};
          refill_d     = 1'b1;
          refill_cls_d = pick;
        end
      end else begin
        idle_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      busy_q       <= '0;
      refill_q     <= 1'b0;
      refill_cls_q <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]  <= '0;
        tail_q[c]  <= '0;
        count_q[c] <= '0;
      end
    end else begin
      if (req_i.valid && req_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      busy_q       <= busy_d;
      refill_q     <= refill_d;
      refill_cls_q <= refill_cls_d;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]  <= head_d[c];
        tail_q[c]  <= tail_d[c];
        count_q[c] <= count_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_item_q <= '{command:       req_i.command,
                     request_class: req_i.request_class,
                     request_id:    req_i.request_id,
                     service_ticks: req_i.service_ticks};
    end
    if (advance) begin
      answered_q <= answered_d;
      ans_id_q   <= ans_id_d;
      ans_cls_q  <= ans_cls_d;
      idle_q     <= idle_d;
      dropped_q  <= dropped_d;
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (front_load[c]) begin
        front_q[c] <= mem_wdata;
      end else if (refill_q && refill_cls_q == CSEL_W'(c)) begin
        front_q[c] <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_q[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(answered_q && idle_q) && !(dropped_q && (answered_q || idle_q)))
    else $error("result word flags not mutually exclusive");

  a_refill_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refill_q |-> count_q[refill_cls_q] != '0)
    else $error("head refill for an empty class");

  a_busy_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_item_q.command == CMD_TICK && busy_q != '0
      |=> busy_q == $past(busy_q) - 1'b1)
    else $error("busy counter did not step down on a busy tick");

  a_ram_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("queue RAM written and read in the same cycle");

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cnt_chk
    a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q[g] <= FULL_CNT)
      else $error("class queue count above depth");
  end

endmodule
